### design/swr_pkg.sv
// Shared types and constants for the sliding window receiver.
`default_nettype none

package swr_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SEQ_COUNT   = 1'b1;

    // Register values after reset
    localparam int WINDOW_SIZE_RESET = 8;
    localparam int SEQ_COUNT_RESET   = 64;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic mod_step;
        logic last_step;
        logic decide;
        logic scan_step;
        logic ack_check;
        logic sweep_step;
        logic out_load;
    } swr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic mod_busy;
        logic last_busy;
        logic is_tick;
        logic need_ack;
        logic scan_stop;
        logic latched;
        logic sweep_last;
        logic out_busy;
    } swr_stat_t;

endpackage

`default_nettype wire

### design/sliding_window_receiver.sv
// Receiver side of a go-back-N sliding window: top level.
//
// Slave stream: one transaction per event. s_tuser = 0 marks a data packet
// (s_tdata carries seq_num and payload_empty), s_tuser = 1 an ack timeout tick.
// Master stream: exactly one result transaction per accepted event, giving
// whether an ack goes out and for which sequence number, whether the payload
// is stored or overwrites an earlier copy, and the closing flag.
// Configuration: cfg_valid/cfg_ready write window_size (index 0) or
// seq_count (index 1); write only while no event is in progress.
// Events are handled one at a time: a packet that sends no ack goes straight to
// the result, a latched ack suppresses the send and the sweep, an ack sweeps
// window_size slots, and a tick first scans the window for the first unwritten
// slot; scan and sweep visit one slot per cycle.
// Pointer reduction after a seq_count change and the last-slot search when
// the window wraps past the end of the sequence space work by repeated
// subtraction of seq_count.
// The result register lets the next event be accepted while a result waits;
// a stalled master side holds the finished event until m_tready.
// Reset empties the window, clears all slot bits and the closing flag, and
// restores window_size 8 and seq_count 64.
`default_nettype none

module sliding_window_receiver
    import swr_pkg::*;
#(
    parameter int SEQ_SPACE_MAX = 64,
    parameter int WINDOW_MAX    = 32,
    localparam int SEQ_W        = $clog2(SEQ_SPACE_MAX),
    localparam int CNT_W        = $clog2(SEQ_SPACE_MAX + 1),
    localparam int WS_W         = $clog2(WINDOW_MAX + 1),
    localparam int CFG_W        = (CNT_W > WS_W) ? CNT_W : WS_W,
    localparam int IN_W         = ((SEQ_W + 1 + 7) / 8) * 8,
    localparam int OUT_W        = ((SEQ_W + 4 + 7) / 8) * 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_W-1:0]      s_tdata,   // seq_num, payload_empty
    input  wire logic                 s_tuser,   // opcode
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [OUT_W-1:0]          m_tdata    // ack_send, ack_seq, store_payload,
                                                 // store_at_old_offset, closing
);

    swr_cmd_t  cmd;
    swr_stat_t stat;

    swr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    swr_dp #(
        .SEQ_SPACE_MAX (SEQ_SPACE_MAX),
        .WINDOW_MAX    (WINDOW_MAX),
        .SEQ_W         (SEQ_W),
        .CNT_W         (CNT_W),
        .WS_W          (WS_W),
        .CFG_W         (CFG_W),
        .IN_W          (IN_W),
        .OUT_W         (OUT_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

### design/swr_ctrl.sv
// Sequencer for the sliding window receiver: one item at a time.
`default_nettype none

module swr_ctrl
    import swr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire swr_stat_t stat,
    output swr_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_LAST,
        ST_DECIDE,
        ST_SCAN,
        ST_ACK,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MOD;
                end
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (!stat.mod_busy)
                    state_next = ST_LAST;
            end
            ST_LAST:
            begin
                cmd.last_step = 1'b1;
                if (!stat.last_busy)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (stat.is_tick)
                    state_next = ST_SCAN;
                else if (stat.need_ack)
                    state_next = ST_ACK;
                else
                    state_next = ST_FINISH;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_stop)
                    state_next = ST_ACK;
            end
            ST_ACK:
            begin
                // a latched ack suppresses the send and the sweep
                cmd.ack_check = 1'b1;
                if (stat.latched)
                    state_next = ST_FINISH;
                else
                    state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

### design/swr_dp.sv
// Datapath: window state, slot bits, sweep pointers and result register.
`default_nettype none

module swr_dp
    import swr_pkg::*;
#(
    parameter int SEQ_SPACE_MAX = 64,
    parameter int WINDOW_MAX    = 32,
    parameter int SEQ_W         = $clog2(SEQ_SPACE_MAX),
    parameter int CNT_W         = $clog2(SEQ_SPACE_MAX + 1),
    parameter int WS_W          = $clog2(WINDOW_MAX + 1),
    parameter int CFG_W         = (CNT_W > WS_W) ? CNT_W : WS_W,
    parameter int IN_W          = ((SEQ_W + 1 + 7) / 8) * 8,
    parameter int OUT_W         = ((SEQ_W + 4 + 7) / 8) * 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic [IN_W-1:0]      s_tdata,
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [OUT_W-1:0]          m_tdata,
    input  wire swr_cmd_t             cmd,
    output swr_stat_t                 stat
);

    localparam int R_W = $clog2(SEQ_SPACE_MAX + WINDOW_MAX);
    localparam int WS_RST  = (WINDOW_MAX < WINDOW_SIZE_RESET) ? WINDOW_MAX : WINDOW_SIZE_RESET;
    localparam int CNT_RST = (SEQ_SPACE_MAX < SEQ_COUNT_RESET) ? SEQ_SPACE_MAX
                                                                 : SEQ_COUNT_RESET;

    // configuration
    logic [WS_W-1:0]  ws_cfg_reg;
    logic [CNT_W-1:0] cnt_cfg_reg;
    logic [WS_W-1:0]  eff_ws;
    logic [CNT_W-1:0] eff_cnt;

    // window state
    logic [SEQ_W-1:0]         start_reg, start_next;
    logic [SEQ_W-1:0]         exp_reg, exp_next;
    logic                     latched_reg, latched_next;
    logic                     close_reg, close_next;
    logic [SEQ_SPACE_MAX-1:0] written_reg, written_next;
    logic [SEQ_SPACE_MAX-1:0] acked_reg, acked_next;

    // per-item working registers
    logic             opcode_reg, opcode_next;
    logic [SEQ_W-1:0] sn_reg, sn_next;
    logic             empty_reg, empty_next;
    logic [R_W-1:0]   wrap_reg, wrap_next;
    logic [SEQ_W-1:0] p_reg, p_next;
    logic [SEQ_W-1:0] ah_reg, ah_next;
    logic [WS_W-1:0]  k_reg, k_next;
    logic [SEQ_W-1:0] acked_sn_reg, acked_sn_next;
    logic             ack_reg, ack_next;
    logic             store_reg, store_next;
    logic             old_reg, old_next;

    // result register
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;

    // decision terms
    logic [CNT_W-1:0] d_sn, d_ex;
    logic [SEQ_W-1:0] last_sn;
    logic             sn_valid, behind, done_slot, in_order, accept_pkt;

    function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] v,
                                                 input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] s;
        s = CNT_W'(v) + CNT_W'(1);
        return (s == c) ? '0 : SEQ_W'(s);
    endfunction

    function automatic logic [SEQ_W-1:0] seq_dec(input logic [SEQ_W-1:0] v,
                                                 input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] s;
        s = (v == '0) ? (c - CNT_W'(1)) : (CNT_W'(v) - CNT_W'(1));
        return SEQ_W'(s);
    endfunction

    always_comb
    begin
        if (ws_cfg_reg == '0)
            eff_ws = WS_W'(1);
        else if (ws_cfg_reg > WS_W'(WINDOW_MAX))
            eff_ws = WS_W'(WINDOW_MAX);
        else
            eff_ws = ws_cfg_reg;

        if (cnt_cfg_reg < CNT_W'(2))
            eff_cnt = CNT_W'(2);
        else if (cnt_cfg_reg > CNT_W'(SEQ_SPACE_MAX))
            eff_cnt = CNT_W'(SEQ_SPACE_MAX);
        else
            eff_cnt = cnt_cfg_reg;
    end

    // packet classification; valid once start/expected are reduced
    always_comb
    begin
        last_sn    = wrap_reg[SEQ_W-1:0];
        sn_valid   = CNT_W'(sn_reg) < eff_cnt;
        d_sn       = CNT_W'(sn_reg) - CNT_W'(start_reg);
        if (sn_reg < start_reg)
            d_sn = d_sn + eff_cnt;
        d_ex       = CNT_W'(exp_reg) - CNT_W'(start_reg);
        if (exp_reg < start_reg)
            d_ex = d_ex + eff_cnt;
        in_order   = (sn_reg == exp_reg);
        behind     = !in_order && (d_sn < d_ex);
        done_slot  = written_reg[sn_reg] && acked_reg[sn_reg];
        accept_pkt = sn_valid && !behind && !done_slot;
    end

    always_comb
    begin
        stat.mod_busy   = (CNT_W'(start_reg) >= eff_cnt) || (CNT_W'(exp_reg) >= eff_cnt);
        stat.last_busy  = wrap_reg >= R_W'(eff_cnt);
        stat.is_tick    = opcode_reg;
        stat.need_ack   = accept_pkt && (!in_order || empty_reg || sn_reg == last_sn);
        stat.scan_stop  = (k_reg == eff_ws) || !written_reg[p_reg];
        stat.latched    = latched_reg;
        stat.sweep_last = (k_reg + WS_W'(1)) == eff_ws;
        stat.out_busy   = out_valid_reg && !m_tready;
    end

    always_comb
    begin
        start_next    = start_reg;
        exp_next      = exp_reg;
        latched_next  = latched_reg;
        close_next    = close_reg;
        written_next  = written_reg;
        acked_next    = acked_reg;
        opcode_next   = opcode_reg;
        sn_next       = sn_reg;
        empty_next    = empty_reg;
        wrap_next     = wrap_reg;
        p_next        = p_reg;
        ah_next       = ah_reg;
        k_next        = k_reg;
        acked_sn_next = acked_sn_reg;
        ack_next      = ack_reg;
        store_next    = store_reg;
        old_next      = old_reg;

        if (cmd.load_in)
        begin
            opcode_next = s_tuser;
            sn_next     = s_tdata[SEQ_W-1:0];
            empty_next  = s_tdata[SEQ_W];
            ack_next    = 1'b0;
            store_next  = 1'b0;
            old_next    = 1'b0;
        end

        // bring window pointers into the current sequence space
        if (cmd.mod_step)
        begin
            if (CNT_W'(start_reg) >= eff_cnt)
                start_next = SEQ_W'(CNT_W'(start_reg) - eff_cnt);
            if (CNT_W'(exp_reg) >= eff_cnt)
                exp_next = SEQ_W'(CNT_W'(exp_reg) - eff_cnt);
            if (!stat.mod_busy)
                wrap_next = R_W'(start_reg) + R_W'(eff_ws) - R_W'(1);
        end

        // last slot of the window by repeated subtraction
        if (cmd.last_step && stat.last_busy)
            wrap_next = wrap_reg - R_W'(eff_cnt);

        if (cmd.decide)
        begin
            if (opcode_reg)
            begin
                latched_next = 1'b0;
                p_next       = start_reg;
                k_next       = '0;
            end
            else if (accept_pkt)
            begin
                if (in_order)
                begin
                    latched_next         = 1'b0;
                    written_next[sn_reg] = 1'b1;
                    acked_sn_next        = sn_reg;
                    if (empty_reg)
                        close_next = 1'b1;
                    else
                    begin
                        store_next = 1'b1;
                        old_next   = written_reg[sn_reg];
                        exp_next   = seq_inc(sn_reg, eff_cnt);
                    end
                end
                else
                    acked_sn_next = seq_dec(exp_reg, eff_cnt);
            end
        end

        // walk to the first unwritten slot
        if (cmd.scan_step)
        begin
            if (stat.scan_stop)
                acked_sn_next = seq_dec(p_reg, eff_cnt);
            else
            begin
                p_next = seq_inc(p_reg, eff_cnt);
                k_next = k_reg + WS_W'(1);
            end
        end

        if (cmd.ack_check && !latched_reg)
        begin
            p_next  = start_reg;
            ah_next = seq_inc(last_sn, eff_cnt);
            k_next  = '0;
        end

        // one slot per cycle; the clear one window ahead wins on overlap
        if (cmd.sweep_step)
        begin
            acked_next[p_reg]    = written_reg[p_reg];
            acked_next[ah_reg]   = 1'b0;
            written_next[ah_reg] = 1'b0;
            p_next  = seq_inc(p_reg, eff_cnt);
            ah_next = seq_inc(ah_reg, eff_cnt);
            k_next  = k_reg + WS_W'(1);
            if (stat.sweep_last)
            begin
                latched_next = 1'b1;
                start_next   = seq_inc(acked_sn_reg, eff_cnt);
                exp_next     = seq_inc(acked_sn_reg, eff_cnt);
                ack_next     = 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready)
            out_valid_next = 1'b0;
        if (cmd.out_load)
        begin
            out_valid_next            = 1'b1;
            out_data_next             = '0;
            out_data_next[0]          = ack_reg;
            out_data_next[SEQ_W:1]    = ack_reg ? acked_sn_reg : '0;
            out_data_next[SEQ_W+1]    = store_reg;
            out_data_next[SEQ_W+2]    = old_reg;
            out_data_next[SEQ_W+3]    = close_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_cfg_reg    <= WS_W'(WS_RST);
            cnt_cfg_reg   <= CNT_W'(CNT_RST);
            start_reg     <= '0;
            exp_reg       <= '0;
            latched_reg   <= 1'b0;
            close_reg     <= 1'b0;
            written_reg   <= '0;
            acked_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == REG_WINDOW_SIZE)
                ws_cfg_reg <= cfg_data[WS_W-1:0];
            if (cfg_valid && cfg_index == REG_SEQ_COUNT)
                cnt_cfg_reg <= cfg_data[CNT_W-1:0];
            start_reg     <= start_next;
            exp_reg       <= exp_next;
            latched_reg   <= latched_next;
            close_reg     <= close_next;
            written_reg   <= written_next;
            acked_reg     <= acked_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opcode_reg   <= opcode_next;
        sn_reg       <= sn_next;
        empty_reg    <= empty_next;
        wrap_reg     <= wrap_next;
        p_reg        <= p_next;
        ah_reg       <= ah_next;
        k_reg        <= k_next;
        acked_sn_reg <= acked_sn_next;
        ack_reg      <= ack_next;
        store_reg    <= store_next;
        old_reg      <= old_next;
        out_data_reg <= out_data_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the sliding window receiver with an item-level ack predictor.
`timescale 1ns / 1ps

module testbench;
    import swr_pkg::*;

    localparam bit OP_DATA = 1'b0;
    localparam bit OP_TICK = 1'b1;
    localparam int unsigned CYCLE_LIMIT = 1500000;
    localparam int NUM_PHASES = 12;
    localparam int PHASE_ITEMS = 140;
    localparam int DRAIN_CYCLES = 200;

    // m_tdata layout, lowest bit first: ack_send, ack_seq, store_payload,
    // store_at_old_offset, closing, zero fill
    typedef struct packed {
        logic [5:0] pad;
        logic       closing;
        logic       old_copy;
        logic       store;
        logic [5:0] ack_seq;
        logic       ack_send;
    } ack_result_t;

    class ack_scoreboard;
        int unsigned win_reg;
        int unsigned cnt_reg;
        bit [5:0] win_start;
        bit [5:0] next_seq;
        bit written[64];
        bit acked[64];
        bit ack_held;
        bit closing;
        ack_result_t ack_q[$];
        int errors;

        function new();
            win_reg = WINDOW_SIZE_RESET;
            cnt_reg = SEQ_COUNT_RESET;
            win_start = '0;
            next_seq = '0;
            ack_held = 1'b0;
            closing = 1'b0;
            errors = 0;
            for (int i = 0; i < 64; i++)
            begin
                written[i] = 1'b0;
                acked[i] = 1'b0;
            end
        endfunction

        function int unsigned eff_window();
            if (win_reg < 1) return 1;
            if (win_reg > 32) return 32;
            return win_reg;
        endfunction

        function int unsigned eff_count();
            if (cnt_reg < 2) return 2;
            if (cnt_reg > 64) return 64;
            return cnt_reg;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [6:0] data);
            if (idx == REG_WINDOW_SIZE)
                win_reg = data[5:0];
            else
                cnt_reg = data;
        endfunction

        // Send an ack of seq a unless one is latched; sweeps the window.
        function bit sweep_window(int unsigned a, int unsigned cnt, int unsigned ws);
            int unsigned s;
            int unsigned ahead;
            if (ack_held) return 1'b0;
            s = win_start % cnt;
            for (int unsigned i = 0; i < ws; i++)
            begin
                acked[s] = written[s];
                ahead = (s + ws) % cnt;
                acked[ahead] = 1'b0;
                written[ahead] = 1'b0;
                s = (s + 1) % cnt;
            end
            ack_held = 1'b1;
            win_start = 6'((a + 1) % cnt);
            next_seq = win_start;
            return 1'b1;
        endfunction

        function void note_item(bit op, bit [5:0] seq, bit empty);
            int unsigned cnt;
            int unsigned ws;
            int unsigned s;
            int unsigned d_sn;
            int unsigned d_ex;
            int unsigned acked_sn;
            bit ack;
            bit store;
            bit old;
            bit behind;
            bit done;
            ack_result_t r;
            cnt = eff_count();
            ws = eff_window();
            ack = 1'b0;
            acked_sn = 0;
            store = 1'b0;
            old = 1'b0;
            win_start = 6'(win_start % cnt);
            next_seq = 6'(next_seq % cnt);
            if (op == OP_TICK)
            begin
                s = win_start;
                ack_held = 1'b0;
                for (int unsigned i = 0; i < ws; i++)
                begin
                    if (!written[s]) break;
                    s = (s + 1) % cnt;
                end
                acked_sn = (s + cnt - 1) % cnt;
                ack = sweep_window(acked_sn, cnt, ws);
            end
            else if (seq < cnt)
            begin
                d_sn = (seq + cnt - win_start) % cnt;
                d_ex = (next_seq + cnt - win_start) % cnt;
                behind = (seq != next_seq) && (d_sn < d_ex);
                done = written[seq] && acked[seq];
                if (!behind && !done)
                begin
                    if (seq == next_seq)
                    begin
                        ack_held = 1'b0;
                        if (empty)
                        begin
                            closing = 1'b1;
                            written[seq] = 1'b1;
                            acked_sn = seq;
                            ack = sweep_window(seq, cnt, ws);
                        end
                        else
                        begin
                            store = 1'b1;
                            old = written[seq];
                            written[seq] = 1'b1;
                            next_seq = 6'((seq + 1) % cnt);
                            // filling the last window slot forces a fast ack
                            if (seq == (win_start + ws - 1) % cnt)
                            begin
                                acked_sn = seq;
                                ack = sweep_window(seq, cnt, ws);
                            end
                        end
                    end
                    else
                    begin
                        acked_sn = (next_seq + cnt - 1) % cnt;
                        ack = sweep_window(acked_sn, cnt, ws);
                    end
                end
            end
            r = '0;
            r.ack_send = ack;
            r.ack_seq = ack ? 6'(acked_sn) : 6'd0;
            r.store = store;
            r.old_copy = old;
            r.closing = closing;
            ack_q.push_back(r);
        endfunction

        function void field_check(string name, logic [5:0] exp_val, logic [5:0] act_val);
            if (act_val !== exp_val)
            begin
                errors++;
                $display("%0t: mismatch on %s: expected %0d, actual %0d",
                         $realtime, name, exp_val, act_val);
            end
        endfunction

        function void check_result(logic [15:0] raw);
            ack_result_t got;
            ack_result_t want;
            got = raw;
            if (ack_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result transaction: expected none, actual %h",
                         $realtime, raw);
                return;
            end
            want = ack_q.pop_front();
            field_check("ack_send", 6'(want.ack_send), 6'(got.ack_send));
            field_check("ack_seq", want.ack_seq, got.ack_seq);
            field_check("store_payload", 6'(want.store), 6'(got.store));
            field_check("store_at_old_offset", 6'(want.old_copy), 6'(got.old_copy));
            field_check("closing", 6'(want.closing), 6'(got.closing));
        endfunction

        function int pending();
            return ack_q.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [6:0]           cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;

    ack_scoreboard sb;
    bit steady = 1'b0;
    int unsigned cycles = 0;
    logic [6:0] phase_win[NUM_PHASES];
    logic [6:0] phase_cnt[NUM_PHASES];

    sliding_window_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
        m_tready <= steady || ($urandom_range(0, 99) >= 17);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);

    // Leaves s_tvalid high after the transaction so back-to-back items need no toggle.
    task automatic send_item(bit op, bit [5:0] seq, bit empty);
        while (!steady && $urandom_range(0, 99) < 17)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {1'b0, empty, seq};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_item(op, seq, empty);
    endtask

    // Both registers in one burst; only with the receiver drained.
    task automatic write_config(logic [6:0] win, logic [6:0] cnt);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= REG_WINDOW_SIZE;
        cfg_data <= win;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(REG_WINDOW_SIZE, win);
        cfg_index <= REG_SEQ_COUNT;
        cfg_data <= cnt;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(REG_SEQ_COUNT, cnt);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        int unsigned cnt;
        int unsigned ws;
        int unsigned r;
        int unsigned back;
        bit [5:0] seq;
        bit op;
        bit empty;
        cnt = sb.eff_count();
        ws = sb.eff_window();
        r = $urandom_range(0, 99);
        op = OP_DATA;
        empty = ($urandom_range(0, 99) < 2);
        seq = 6'($urandom);
        if (r < 10)
        begin
            op = OP_TICK;
            empty = 1'($urandom_range(0, 1));
        end
        else if (r < 15)
            empty = 1'($urandom_range(0, 1));   // noise over the whole field
        else if (r < 75)
            seq = 6'(sb.next_seq % cnt);
        else if (r < 88)
            seq = 6'((sb.next_seq % cnt + $urandom_range(1, ws)) % cnt);
        else if (r < 95)
        begin
            back = $urandom_range(1, ws) % cnt;
            seq = 6'((sb.win_start % cnt + cnt - back) % cnt);
        end
        else
            seq = 6'($urandom_range(0, cnt - 1));
        send_item(op, seq, empty);
    endtask

    initial
    begin
        sb = new();
        phase_win = '{7'd8, 7'd1, 7'd32, 7'd0, 7'd63, 7'd5, 7'd20, 7'd3, 7'd16, 7'd33,
                      7'd0, 7'd0};
        phase_cnt = '{7'd64, 7'd2, 7'd64, 7'd0, 7'd127, 7'd10, 7'd30, 7'd7, 7'd33, 7'd100,
                      7'd0, 7'd0};
        phase_win[10] = 7'($urandom_range(0, 63));
        phase_cnt[10] = 7'($urandom_range(0, 127));
        phase_win[11] = 7'($urandom_range(0, 63));
        phase_cnt[11] = 7'($urandom_range(0, 127));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: tick at reset, fill window, latched drop, tick, ooo, drops
        send_item(OP_TICK, 6'd0, 1'b0);
        for (int i = 0; i < 8; i++)
            send_item(OP_DATA, 6'(i), 1'b0);
        send_item(OP_DATA, 6'd20, 1'b0);
        send_item(OP_TICK, 6'd63, 1'b1);
        send_item(OP_DATA, 6'd8, 1'b0);
        send_item(OP_DATA, 6'd9, 1'b0);
        send_item(OP_DATA, 6'd12, 1'b0);
        send_item(OP_DATA, 6'd9, 1'b0);
        send_item(OP_DATA, 6'd10, 1'b0);
        send_item(OP_DATA, 6'd11, 1'b0);
        send_item(OP_DATA, 6'd10, 1'b0);
        send_item(OP_DATA, 6'd63, 1'b1);
        send_item(OP_DATA, 6'd0, 1'b0);
        send_item(OP_DATA, 6'd63, 1'b0);
        send_item(OP_DATA, sb.next_seq, 1'b1);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
                write_config(phase_win[p], phase_cnt[p]);
            steady = (p == 4);
            for (int k = 0; k < PHASE_ITEMS; k++)
                random_item();
        end
        steady = 1'b0;

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
